### hdl/lia_pkg.sv
// ----------------------------------------------------------------------------
// lia_pkg
// Shared types and constants for the listen interval aligner: interval
// width, sequencer states, outcome codes and the divider request/response.
// ----------------------------------------------------------------------------
package lia_pkg;

    localparam int IV_BITS      = 24;
    localparam int D_BITS       = IV_BITS / 2 + 1;  // trial divisor, up to isqrt(max) + 1
    localparam int SQ_BITS      = IV_BITS + 2;      // running square of the trial divisor
    localparam int CNT_BITS     = $clog2(IV_BITS);
    localparam int OUTCOME_BITS = 3;

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_INVALID  = 3'd0,
        OUT_ALIGNED  = 3'd1,
        OUT_EXTENDED = 3'd2,
        OUT_REDUCED  = 3'd3,
        OUT_NONE     = 3'd4
    } outcome_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_UP,
        ST_DIV_DN,
        ST_ASC_TEST,
        ST_ASC_DIV,
        ST_DESC_TEST,
        ST_DESC_Q,
        ST_DESC_R,
        ST_FIN,
        ST_FIN_HI,
        ST_FIN_LO,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [IV_BITS-1:0] dividend;
        logic [IV_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [IV_BITS-1:0] quot;
        logic [IV_BITS-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [IV_BITS-1:0] adjusted;
        outcome_t           outcome;
    } res_t;

endpackage

### hdl/lia_div.sv
// ----------------------------------------------------------------------------
// lia_div
// Restoring radix-2 divider, one quotient bit per cycle. Start is taken
// when idle; done pulses for one cycle, quotient and remainder then hold.
// ----------------------------------------------------------------------------
module lia_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  lia_pkg::div_req_t div_req,
    output lia_pkg::div_rsp_t div_rsp
);

    localparam int N  = lia_pkg::IV_BITS;
    localparam int CW = lia_pkg::CNT_BITS;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  quot_reg, quot_next;
    logic [N-1:0]  rem_reg, rem_next;
    logic [N-1:0]  dvs_reg, dvs_next;
    logic [N:0]    rem_sh;
    logic [N:0]    rem_sub;
    logic          ge;

    assign rem_sh  = {rem_reg, quot_reg[N-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg) begin
            rem_next  = ge ? rem_sub[N-1:0] : rem_sh[N-1:0];
            quot_next = {quot_reg[N-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = div_req.dividend;
            rem_next  = '0;
            dvs_next  = div_req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quot_reg;
    assign div_rsp.rem  = rem_reg;

endmodule

### hdl/lia_seq.sv
// ----------------------------------------------------------------------------
// lia_seq
// Sequencer: range checks, then multiple rounding and the divisor search, the
// latter two driving the one shared divider.
// ----------------------------------------------------------------------------
module lia_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lia_pkg::IV_BITS-1:0] bcast,
    input  logic [lia_pkg::IV_BITS-1:0] uc,
    input  logic [lia_pkg::IV_BITS-1:0] mn,
    input  logic [lia_pkg::IV_BITS-1:0] mx,
    output logic                       idle,
    output lia_pkg::res_t              res,
    input  logic                       res_ack,
    output lia_pkg::div_req_t          div_req,
    input  lia_pkg::div_rsp_t          div_rsp
);

    localparam int N  = lia_pkg::IV_BITS;
    localparam int DW = lia_pkg::D_BITS;
    localparam int SW = lia_pkg::SQ_BITS;

    lia_pkg::state_t   state_reg, state_next;
    lia_pkg::outcome_t code_reg, code_next;
    logic [N-1:0]  uc_reg, uc_next;
    logic [N-1:0]  mn_reg, mn_next;
    logic [N-1:0]  mx_reg, mx_next;
    logic [N-1:0]  ref_reg, ref_next;
    logic [N-1:0]  lo_reg, lo_next;
    logic [N-1:0]  hi_reg, hi_next;
    logic [N-1:0]  c_reg, c_next;
    logic [N-1:0]  adj_reg, adj_next;
    logic [DW-1:0] d_reg, d_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [N:0]    ext_sum;
    logic [N-1:0]  red_diff;
    logic [N-1:0]  d_ext;

    // rounding candidates for the long-request case, remainder from the divider
    assign ext_sum  = {1'b0, uc_reg} + {1'b0, bcast} - {1'b0, div_rsp.rem};
    assign red_diff = uc_reg - div_rsp.rem;
    assign d_ext    = N'(d_reg);

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        uc_next    = uc_reg;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        ref_next   = ref_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        c_next     = c_reg;
        adj_next   = adj_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        div_req.start    = 1'b0;
        div_req.dividend = bcast;
        div_req.divisor  = uc_reg;

        unique case (state_reg)
            lia_pkg::ST_IDLE: begin
                if (start) begin
                    uc_next    = uc;
                    mn_next    = mn;
                    mx_next    = mx;
                    state_next = lia_pkg::ST_CHECK;
                end
            end
            lia_pkg::ST_CHECK: begin
                if (bcast == '0 || uc_reg == '0 || mn_reg == '0 || mx_reg == '0 ||
                    uc_reg < mn_reg || uc_reg > mx_reg) begin
                    adj_next   = '0;
                    code_next  = lia_pkg::OUT_INVALID;
                    state_next = lia_pkg::ST_DONE;
                end else if (uc_reg > bcast) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = uc_reg;
                    div_req.divisor  = bcast;
                    state_next       = lia_pkg::ST_DIV_UP;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = lia_pkg::ST_DIV_DN;
                end
            end
            lia_pkg::ST_DIV_UP: begin
                if (div_rsp.done) begin
                    state_next = lia_pkg::ST_DONE;
                    if (div_rsp.rem == '0) begin
                        adj_next  = uc_reg;
                        code_next = lia_pkg::OUT_ALIGNED;
                    end else if (ext_sum <= {1'b0, mx_reg}) begin
                        adj_next  = ext_sum[N-1:0];
                        code_next = lia_pkg::OUT_EXTENDED;
                    end else if (red_diff >= mn_reg) begin
                        adj_next  = red_diff;
                        code_next = lia_pkg::OUT_REDUCED;
                    end else begin
                        adj_next  = uc_reg;
                        code_next = lia_pkg::OUT_NONE;
                    end
                end
            end
            lia_pkg::ST_DIV_DN: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        adj_next   = uc_reg;
                        code_next  = lia_pkg::OUT_ALIGNED;
                        state_next = lia_pkg::ST_DONE;
                    end else begin
                        ref_next   = div_rsp.quot;
                        lo_next    = '0;
                        hi_next    = '0;
                        d_next     = DW'(1);
                        sq_next    = SW'(1);
                        state_next = lia_pkg::ST_ASC_TEST;
                    end
                end
            end
            lia_pkg::ST_ASC_TEST: begin
                if (sq_reg <= SW'(bcast)) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = d_ext;
                    state_next      = lia_pkg::ST_ASC_DIV;
                end else begin
                    d_next     = d_reg - 1'b1;
                    state_next = lia_pkg::ST_DESC_TEST;
                end
            end
            lia_pkg::ST_ASC_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0 && d_ext > ref_reg) begin
                        hi_next    = d_ext;
                        state_next = lia_pkg::ST_FIN;
                    end else begin
                        if (div_rsp.rem == '0) begin
                            lo_next = d_ext;
                        end
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + SW'({d_reg, 1'b1});
                        d_next     = d_reg + 1'b1;
                        state_next = lia_pkg::ST_ASC_TEST;
                    end
                end
            end
            lia_pkg::ST_DESC_TEST: begin
                if (d_reg == '0) begin
                    state_next = lia_pkg::ST_FIN;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.divisor = d_ext;
                    state_next      = lia_pkg::ST_DESC_Q;
                end
            end
            lia_pkg::ST_DESC_Q: begin
                if (div_rsp.done) begin
                    c_next = div_rsp.quot;
                    if (div_rsp.quot == '0) begin
                        d_next     = d_reg - 1'b1;
                        state_next = lia_pkg::ST_DESC_TEST;
                    end else begin
                        div_req.start   = 1'b1;
                        div_req.divisor = div_rsp.quot;
                        state_next      = lia_pkg::ST_DESC_R;
                    end
                end
            end
            lia_pkg::ST_DESC_R: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0 && c_reg > ref_reg) begin
                        hi_next    = c_reg;
                        state_next = lia_pkg::ST_FIN;
                    end else begin
                        if (div_rsp.rem == '0) begin
                            lo_next = c_reg;
                        end
                        d_next     = d_reg - 1'b1;
                        state_next = lia_pkg::ST_DESC_TEST;
                    end
                end
            end
            lia_pkg::ST_FIN: begin
                if (hi_reg != '0) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = hi_reg;
                    state_next      = lia_pkg::ST_FIN_HI;
                end else if (lo_reg != '0) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = lo_reg;
                    state_next      = lia_pkg::ST_FIN_LO;
                end else begin
                    adj_next   = uc_reg;
                    code_next  = lia_pkg::OUT_NONE;
                    state_next = lia_pkg::ST_DONE;
                end
            end
            lia_pkg::ST_FIN_HI: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= mn_reg) begin
                        adj_next   = div_rsp.quot;
                        code_next  = lia_pkg::OUT_REDUCED;
                        state_next = lia_pkg::ST_DONE;
                    end else if (lo_reg != '0) begin
                        div_req.start   = 1'b1;
                        div_req.divisor = lo_reg;
                        state_next      = lia_pkg::ST_FIN_LO;
                    end else begin
                        adj_next   = uc_reg;
                        code_next  = lia_pkg::OUT_NONE;
                        state_next = lia_pkg::ST_DONE;
                    end
                end
            end
            lia_pkg::ST_FIN_LO: begin
                if (div_rsp.done) begin
                    state_next = lia_pkg::ST_DONE;
                    if (div_rsp.quot <= mx_reg) begin
                        adj_next  = div_rsp.quot;
                        code_next = lia_pkg::OUT_EXTENDED;
                    end else begin
                        adj_next  = uc_reg;
                        code_next = lia_pkg::OUT_NONE;
                    end
                end
            end
            lia_pkg::ST_DONE: begin
                if (res_ack) begin
                    state_next = lia_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lia_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lia_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        uc_reg   <= uc_next;
        mn_reg   <= mn_next;
        mx_reg   <= mx_next;
        ref_reg  <= ref_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        c_reg    <= c_next;
        adj_reg  <= adj_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
    end

    assign idle         = (state_reg == lia_pkg::ST_IDLE);
    assign res.valid    = (state_reg == lia_pkg::ST_DONE);
    assign res.adjusted = adj_reg;
    assign res.outcome  = code_reg;

endmodule

### hdl/listen_interval_aligner_core.sv
// ----------------------------------------------------------------------------
// listen_interval_aligner_core
// Aligns a requested listening interval to the configured broadcast interval.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_wr_en/cfg_wr_data load the broadcast interval; write only while idle.
//  - s_* takes one word (request, min, max); m_* returns one word per input
//    (adjusted interval, outcome code).
//  - One word at a time: s_ready is high only while the sequencer is idle.
//  - Every division runs on one shared radix-2 divider.
//  - Path from input handshake to m_valid: an invalid word needs only the range
//    check; the long-request case or a request that already divides the
//    interval needs one division; any other request runs the divisor search,
//    with A ascending and D descending trials, each at most
//    isqrt(broadcast interval).
//  - The result sits in an output register, so the next word is accepted
//    while m_valid waits on m_ready; a finished result stalls the sequencer
//    only if that register is still occupied.
//  - Reset (aresetn low, synchronous) clears the broadcast interval to 0,
//    idles the sequencer and divider, and empties the output register.
// ----------------------------------------------------------------------------
module listen_interval_aligner_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lia_pkg::IV_BITS-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lia_pkg::IV_BITS-1:0]         s_uc_request,
    input  logic [lia_pkg::IV_BITS-1:0]         s_uc_min,
    input  logic [lia_pkg::IV_BITS-1:0]         s_uc_max,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lia_pkg::IV_BITS-1:0]         m_adjusted,
    output logic [lia_pkg::OUTCOME_BITS-1:0]    m_outcome
);

    logic [lia_pkg::IV_BITS-1:0] bcast_reg;
    logic                        seq_idle;
    logic                        seq_start;
    logic                        res_ack;
    lia_pkg::res_t               res;
    lia_pkg::div_req_t           div_req;
    lia_pkg::div_rsp_t           div_rsp;

    logic                        m_valid_reg, m_valid_next;
    logic [lia_pkg::IV_BITS-1:0] m_adjusted_reg;
    lia_pkg::outcome_t           m_outcome_reg;

    // broadcast interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcast_reg <= '0;
        end else if (cfg_wr_en) begin
            bcast_reg <= cfg_wr_data;
        end
    end

    assign s_ready   = seq_idle;
    assign seq_start = s_valid && seq_idle;

    lia_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seq_start),
        .bcast   (bcast_reg),
        .uc      (s_uc_request),
        .mn      (s_uc_min),
        .mx      (s_uc_max),
        .idle    (seq_idle),
        .res     (res),
        .res_ack (res_ack),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    lia_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // output register: take a finished word when the slot is free or draining
    assign res_ack = res.valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ack) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            m_adjusted_reg <= res.adjusted;
            m_outcome_reg  <= res.outcome;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_adjusted = m_adjusted_reg;
    assign m_outcome  = m_outcome_reg;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for listen_interval_aligner_core. A scoreboard class
// predicts each result from the accepted input word and the broadcast
// interval last written. Results are compared field by field in order.
// Stimulus is a directed set of corner cases followed by randomised phases,
// each with its own broadcast interval. Both handshakes idle at random, with
// one long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------

class interval_scoreboard;

    typedef struct packed {
        logic [lia_pkg::IV_BITS-1:0] req;
        logic [lia_pkg::IV_BITS-1:0] adjusted;
        lia_pkg::outcome_t           outcome;
    } aligned_word_t;

    logic [lia_pkg::IV_BITS-1:0] bcast      = '0;
    int unsigned                 mismatches = 0;
    aligned_word_t               expected_words[$];

    function void set_bcast(input logic [lia_pkg::IV_BITS-1:0] v);
        bcast = v;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Nearest divisors of v around the quotient: lo <= near < hi, 0 = none.
    // Trial division up to the square root, then the cofactors upwards.
    function void find_divisors(input longint unsigned v, input longint unsigned near,
                                output longint unsigned lo, output longint unsigned hi);
        longint unsigned d;
        longint unsigned c;
        lo = 0;
        hi = 0;
        for (d = 1; d * d <= v; d++) begin
            if (v % d == 0) begin
                if (d <= near) begin
                    lo = d;
                end else begin
                    hi = d;
                    return;
                end
            end
        end
        for (d = d - 1; d > 0; d--) begin
            c = v / d;
            if (c != 0 && v % c == 0) begin
                if (c <= near) begin
                    lo = c;
                end else begin
                    hi = c;
                    return;
                end
            end
        end
    endfunction

    function aligned_word_t align_interval(input logic [lia_pkg::IV_BITS-1:0] req,
                                           input logic [lia_pkg::IV_BITS-1:0] mn,
                                           input logic [lia_pkg::IV_BITS-1:0] mx);
        aligned_word_t   w;
        longint unsigned bc, uc, lo_w, hi_w, rem, val;
        w.req      = req;
        w.adjusted = '0;
        w.outcome  = lia_pkg::OUT_INVALID;
        bc = bcast;
        uc = req;
        val = 0;
        if (bc == 0 || uc == 0 || mn == 0 || mx == 0) return w;
        if (uc < mn || uc > mx) return w;
        if (uc > bc) begin
            rem = uc % bc;
            if (rem == 0) begin
                val = uc;
                w.outcome = lia_pkg::OUT_ALIGNED;
            end else if (uc + bc - rem <= mx) begin
                // 64-bit sum, so no wrap at the interval width
                val = uc + bc - rem;
                w.outcome = lia_pkg::OUT_EXTENDED;
            end else if (uc - rem >= mn) begin
                val = uc - rem;
                w.outcome = lia_pkg::OUT_REDUCED;
            end else begin
                val = uc;
                w.outcome = lia_pkg::OUT_NONE;
            end
        end else if (bc % uc == 0) begin
            val = uc;
            w.outcome = lia_pkg::OUT_ALIGNED;
        end else begin
            find_divisors(bc, bc / uc, lo_w, hi_w);
            if (hi_w != 0 && bc / hi_w >= mn) begin
                val = bc / hi_w;
                w.outcome = lia_pkg::OUT_REDUCED;
            end else if (lo_w != 0 && bc / lo_w <= mx) begin
                val = bc / lo_w;
                w.outcome = lia_pkg::OUT_EXTENDED;
            end else begin
                val = uc;
                w.outcome = lia_pkg::OUT_NONE;
            end
        end
        w.adjusted = val[lia_pkg::IV_BITS-1:0];
        return w;
    endfunction

    function void note_word(input logic [lia_pkg::IV_BITS-1:0] req,
                            input logic [lia_pkg::IV_BITS-1:0] mn,
                            input logic [lia_pkg::IV_BITS-1:0] mx);
        expected_words.push_back(align_interval(req, mn, mx));
    endfunction

    task report(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_word(input logic [lia_pkg::IV_BITS-1:0] adj,
                    input logic [lia_pkg::OUTCOME_BITS-1:0] oc);
        aligned_word_t w;
        if (expected_words.size() == 0) begin
            report($sformatf("unexpected word: adjusted %0d outcome %0d", adj, oc));
            return;
        end
        w = expected_words.pop_front();
        if (adj !== w.adjusted)
            report($sformatf("request %0d: adjusted %0d, want %0d", w.req, adj, w.adjusted));
        if (oc !== w.outcome)
            report($sformatf("request %0d: outcome %0d, want %0d", w.req, oc, w.outcome));
    endtask

endclass

module tb;

    localparam int              IVW         = lia_pkg::IV_BITS;
    localparam longint unsigned IV_MAX      = (64'd1 << IVW) - 1;
    // above this the divisor search gets slow, so small requests are avoided
    localparam longint unsigned BIG_BC      = 65535;
    localparam int              WORDS_PER_PHASE = 12;
    localparam int              RAND_PHASES = 8;
    localparam int              HOLD_CYCLES = 2000;  // long output hold-off
    localparam int              TAIL_CYCLES = 50;    // catches stray results

    logic                                aclk         = 1'b0;
    logic                                aresetn      = 1'b0;
    logic                                cfg_wr_en    = 1'b0;
    logic [IVW-1:0]                      cfg_wr_data  = '0;
    logic                                s_valid      = 1'b0;
    logic                                s_ready;
    logic [IVW-1:0]                      s_uc_request = '0;
    logic [IVW-1:0]                      s_uc_min     = '0;
    logic [IVW-1:0]                      s_uc_max     = '0;
    logic                                m_valid;
    logic                                m_ready      = 1'b0;
    logic [IVW-1:0]                      m_adjusted;
    logic [lia_pkg::OUTCOME_BITS-1:0]    m_outcome;

    // rush_mode: no idling on either side; squeeze_req: ask the sink for
    // one long hold-off while the source keeps offering words
    bit rush_mode   = 1'b0;
    bit squeeze_req = 1'b0;

    interval_scoreboard sb = new();

    listen_interval_aligner_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_uc_request (s_uc_request),
        .s_uc_min     (s_uc_min),
        .s_uc_max     (s_uc_max),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_adjusted   (m_adjusted),
        .m_outcome    (m_outcome)
    );

    always #4 aclk = ~aclk;

    // Wide spread of magnitudes: random value shifted down by a random amount
    function automatic longint unsigned rand_span();
        return ({32'd0, $urandom} & IV_MAX) >> $urandom_range(0, IVW - 1);
    endfunction

    function automatic longint unsigned noise_field();
        longint unsigned v;
        v = {32'd0, $urandom} & IV_MAX;
        if ($urandom_range(0, 7) == 0) v = 0;
        return v;
    endfunction

    // Offer one word after a random gap; returns at the falling edge after
    // acceptance with valid still high, so a back-to-back word keeps it up.
    task automatic drive_word(input logic [IVW-1:0] req, input logic [IVW-1:0] mn,
                              input logic [IVW-1:0] mx);
        int gap;
        gap = rush_mode ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_uc_request = req;
        s_uc_min     = mn;
        s_uc_max     = mx;
        s_valid      = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(req, mn, mx);
        @(negedge aclk);
    endtask

    // Register write only once every outstanding result has come back
    task automatic apply_bcast(input longint unsigned bc);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = bc[IVW-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_bcast(bc[IVW-1:0]);
    endtask

    // Multiply by a random small prime while it stays modest
    task automatic t_mul(inout longint unsigned v);
        longint unsigned f;
        case ($urandom_range(0, 2))
            0:       f = 2;
            1:       f = 3;
            default: f = 5;
        endcase
        if (v * f <= 5000) v = v * f;
    endtask

    // Mostly well-formed words built round the broadcast interval, the rest
    // broken ranges or plain noise
    task automatic random_word(input longint unsigned bc);
        longint unsigned uc, mn, mx, t;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            case ($urandom_range(0, 3))
                0:       uc = (bc == 0 ? 64'd1 : bc) * $urandom_range(1, 8);
                1:       uc = bc + rand_span();
                2:       uc = (bc == 0 ? rand_span() : bc / $urandom_range(1, 64))
                              + $urandom_range(0, 2);
                default: uc = rand_span();
            endcase
            if (uc > IV_MAX) uc = IV_MAX;
            if (bc > BIG_BC && uc < (bc >> 6)) uc = bc >> 6;
            if (uc == 0) uc = 1;
            mn = uc - (uc >> $urandom_range(1, IVW));
            mx = uc + (rand_span() >> $urandom_range(0, IVW));
            if (mx > IV_MAX) mx = IV_MAX;
            if (pick == 6) begin
                // swapped bounds: min above max
                t  = mn;
                mn = mx;
                mx = t;
            end
        end else begin
            uc = noise_field();
            mn = noise_field();
            mx = noise_field();
        end
        drive_word(uc[IVW-1:0], mn[IVW-1:0], mx[IVW-1:0]);
    endtask

    // Result sink: random stall before each word, plus the one long hold-off
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_ready     = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = rush_mode ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_word(m_adjusted, m_outcome);
        end
    end

    // Run guard: far above the slowest legal run (two full divisor searches
    // at the widest interval plus the random phases)
    initial begin : run_guard
        #50_000_000;
        $display("listen_interval_aligner_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        longint unsigned bc;
        int phase;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Reset value of the interval is zero: everything invalid
        drive_word(24'd100, 24'd50, 24'd200);

        apply_bcast(360);
        drive_word(24'd0,   24'd1,   24'd10);   // zero request
        drive_word(24'd10,  24'd0,   24'd20);   // zero min
        drive_word(24'd10,  24'd1,   24'd0);    // zero max
        drive_word(24'd5,   24'd10,  24'd20);   // below min
        drive_word(24'd30,  24'd10,  24'd20);   // above max
        drive_word(24'd15,  24'd20,  24'd10);   // min above max
        drive_word(24'd720, 24'd1,   24'd1000); // long, already a multiple
        drive_word(24'd500, 24'd1,   24'd1000); // long, round up
        drive_word(24'd500, 24'd1,   24'd600);  // long, round down
        drive_word(24'd500, 24'd400, 24'd600);  // long, nothing in range
        drive_word(24'd90,  24'd1,   24'd100);  // short, exact divisor
        drive_word(24'd100, 24'd1,   24'd200);  // short, sub-multiple below
        drive_word(24'd100, 24'd95,  24'd200);  // short, sub-multiple above
        drive_word(24'd100, 24'd95,  24'd110);  // short, nothing in range
        drive_word(24'd360, 24'd1,   24'd400);  // request equals interval

        apply_bcast(IV_MAX);
        drive_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drive_word(24'hFFFFFE, 24'd1, 24'hFFFFFF);
        // smallest awkward request: full ascending and descending search
        drive_word(24'd2, 24'd1, 24'hFFFFFF);

        // Round-up sum passes the top of the range and must not wrap
        apply_bcast(24'h800001);
        drive_word(24'hFFFFFF, 24'd1, 24'hFFFFFF);
        drive_word(24'hFFFFFF, 24'h900000, 24'hFFFFFF);

        apply_bcast(1);
        drive_word(24'd1, 24'd1, 24'd1);
        drive_word(24'hFFFFFF, 24'd1, 24'hFFFFFF);

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0:       bc = 0;
                1:       bc = $urandom_range(2, 64);
                3: begin
                    // smooth number with plenty of divisors
                    bc = 1;
                    repeat ($urandom_range(3, 10)) begin
                        t_mul(bc);
                    end
                end
                4:       bc = IV_MAX;
                6:       bc = 1;
                default: bc = $urandom_range(65, 5000);
            endcase
            apply_bcast(bc);
            rush_mode   = (phase == 2 || phase == 6);
            squeeze_req = (phase == 1);
            repeat (WORDS_PER_PHASE) random_word(bc);
        end

        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("listen_interval_aligner_core regression: pass");
        end else begin
            $display("listen_interval_aligner_core regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/lia_pkg.sv
hdl/lia_div.sv
hdl/lia_seq.sv
hdl/listen_interval_aligner_core.sv
verif/tb.sv
